// ----- rtl/fmafp_pkg.sv -----
// shared types, format constants and helper functions of the fused multiply-add unit
package fmafp_pkg;

  localparam int MANT_W   = 53;
  localparam int EXP_W    = 14;
  localparam int PROD_W   = 2 * MANT_W;
  localparam int WIDE_W   = 128;
  localparam int PAD_W    = 64 - MANT_W;

  typedef logic signed [EXP_W-1:0] exp_t;
  typedef logic [MANT_W-1:0]       mant_t;

  typedef enum logic {
    MODE_B64 = 1'b0,
    MODE_B32 = 1'b1
  } mode_t;

  // exponent offsets: value = mantissa * 2^(field - offset), mantissa msb at bit 52
  localparam exp_t B64_OFS = exp_t'(1075);
  localparam exp_t B32_OFS = exp_t'(179);

  // rounding constants per format
  localparam exp_t EU_OVF64  = exp_t'(1024);
  localparam exp_t EU_OVF32  = exp_t'(128);
  localparam exp_t EMIN64    = exp_t'(-1022);
  localparam exp_t EMIN32    = exp_t'(-126);
  localparam exp_t MB64      = exp_t'(52);
  localparam exp_t MB32      = exp_t'(23);
  localparam exp_t LSB_SUB64 = exp_t'(-1074);
  localparam exp_t LSB_SUB32 = exp_t'(-149);
  localparam exp_t BIAS_M1_64 = exp_t'(1022);
  localparam exp_t BIAS_M1_32 = exp_t'(126);

  localparam logic [63:0] QNAN64 = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] QNAN32 = 64'h0000_0000_7FC0_0000;
  localparam logic [63:0] INF64  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] INF32  = 64'h0000_0000_7F80_0000;
  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SIGN32 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] QBIT64 = 64'h0008_0000_0000_0000;
  localparam logic [63:0] QBIT32 = 64'h0000_0000_0040_0000;

  typedef struct packed {
    mode_t       mode;
    logic [63:0] factor_a;
    logic [63:0] factor_b;
    logic [63:0] addend;
  } operand_t;

  typedef struct packed {
    logic [63:0] sum_bits;
    logic        invalid_flag;
  } result_t;

  // special-case outcome that rides along with every beat
  typedef struct packed {
    mode_t       mode;
    logic        special;
    logic [63:0] spec_bits;
    logic        spec_inv;
  } tag_t;

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
    logic        zero;
    exp_t        ue;
    mant_t       m;
    logic [63:0] bits;
  } op_t;

  // addend side that travels next to the multiplier
  typedef struct packed {
    tag_t  tag;
    mant_t mc;
    exp_t  ec;
    logic  sp;
    logic  sc;
    logic  c_zero;
  } side_t;

  typedef struct packed {
    side_t side;
    mant_t ma;
    mant_t mb;
    exp_t  ea;
    exp_t  eb;
  } norm_t;

  typedef struct packed {
    side_t             side;
    logic [PROD_W-1:0] p;
    exp_t              pe;
  } prod_t;

  typedef struct packed {
    tag_t              tag;
    logic [WIDE_W-1:0] r;
    exp_t              e0;
    logic              rs;
  } sum_t;

  // index of the highest set bit of a 16-bit chunk, zero when empty
  function automatic logic [3:0] msb16(input logic [15:0] v);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  // split one operand into sign, class, unified exponent and 53-bit mantissa
  function automatic op_t unpack_op(input mode_t mode, input logic [63:0] x);
    logic [10:0] e_fld;
    logic [51:0] f_fld;
    logic [10:0] e_use;
    logic        all1;
    logic        ez;
    logic        fz;
    exp_t        ofs;
    op_t         o;
    if (mode == MODE_B32) begin
      o.bits = {32'b0, x[31:0]};
      o.sign = x[31];
      e_fld  = {3'b0, x[30:23]};
      f_fld  = {x[22:0], 29'b0};
      all1   = &x[30:23];
      ofs    = B32_OFS;
    end else begin
      o.bits = x;
      o.sign = x[63];
      e_fld  = x[62:52];
      f_fld  = x[51:0];
      all1   = &x[62:52];
      ofs    = B64_OFS;
    end
    ez     = (e_fld == '0);
    fz     = (f_fld == '0);
    o.nan  = all1 && !fz;
    o.inf  = all1 && fz;
    o.zero = ez && fz;
    o.m    = {!ez, f_fld};
    e_use  = ez ? 11'd1 : e_fld;
    o.ue   = exp_t'(e_use) - ofs;
    return o;
  endfunction

endpackage

// ----- rtl/fmafp_unpack.sv -----
// operand decode, special cases and mantissa normalization (three stages)
module fmafp_unpack import fmafp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     operand_valid,
  output logic     operand_ready,
  input  operand_t operand,
  output logic     norm_valid,
  input  logic     norm_ready,
  output norm_t    norm
);

  // special-case result of one operation
  function automatic tag_t special_case(input mode_t mode, input op_t a, input op_t b,
                                        input op_t c);
    logic        sp;
    logic [63:0] qb;
    logic [63:0] dn;
    logic [63:0] infb;
    logic [63:0] sb;
    tag_t        t;
    sp   = a.sign ^ b.sign;
    qb   = (mode == MODE_B32) ? QBIT32 : QBIT64;
    dn   = (mode == MODE_B32) ? QNAN32 : QNAN64;
    infb = (mode == MODE_B32) ? INF32 : INF64;
    sb   = (mode == MODE_B32) ? SIGN32 : SIGN64;
    t.mode      = mode;
    t.special   = 1'b1;
    t.spec_inv  = 1'b0;
    t.spec_bits = '0;
    if (a.nan) begin
      t.spec_bits = a.bits | qb;
    end else if (b.nan) begin
      t.spec_bits = b.bits | qb;
    end else if ((a.zero && b.inf) || (b.zero && a.inf)) begin
      t.spec_bits = dn;
      t.spec_inv  = 1'b1;
    end else if (a.inf || b.inf) begin
      if (c.nan) begin
        t.spec_bits = c.bits | qb;
      end else if (c.inf && (c.sign != sp)) begin
        t.spec_bits = dn;
        t.spec_inv  = 1'b1;
      end else begin
        t.spec_bits = (sp ? sb : 64'b0) | infb;
      end
    end else if (c.nan) begin
      t.spec_bits = c.bits | qb;
    end else if (c.inf) begin
      t.spec_bits = c.bits;
    end else if (a.zero || b.zero) begin
      if (c.zero) t.spec_bits = (sp && c.sign) ? sb : 64'b0;
      else        t.spec_bits = c.bits;
    end else begin
      t.special = 1'b0;
    end
    return t;
  endfunction

  logic v1, v2, v3;
  logic en1, en2, en3;
  norm_t s1, s2, s3;
  norm_t s1_next, s3_next;
  logic [2:0][3:0]       nz2, nz2_next;
  logic [2:0][3:0][3:0]  idx2, idx2_next;

  // stall chain: a stage moves when empty or when the next one moves
  assign en3 = !v3 || norm_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign operand_ready = en1;
  assign norm_valid    = v3;
  assign norm          = s3;

  // stage 1: decode
  always_comb begin
    op_t oa, ob, oc;
    oa = unpack_op(operand.mode, operand.factor_a);
    ob = unpack_op(operand.mode, operand.factor_b);
    oc = unpack_op(operand.mode, operand.addend);
    s1_next.side.tag    = special_case(operand.mode, oa, ob, oc);
    s1_next.side.mc     = oc.m;
    s1_next.side.ec     = oc.ue;
    s1_next.side.sp     = oa.sign ^ ob.sign;
    s1_next.side.sc     = oc.sign;
    s1_next.side.c_zero = oc.zero;
    s1_next.ma          = oa.m;
    s1_next.mb          = ob.m;
    s1_next.ea          = oa.ue;
    s1_next.eb          = ob.ue;
  end

  // stage 2: per-chunk leading one search on the three mantissas
  always_comb begin
    logic [2:0][63:0] mp;
    mp[0] = {s1.ma, PAD_W'(0)};
    mp[1] = {s1.mb, PAD_W'(0)};
    mp[2] = {s1.side.mc, PAD_W'(0)};
    for (int o = 0; o < 3; o++) begin
      for (int j = 0; j < 4; j++) begin
        nz2_next[o][j]  = |mp[o][16*j +: 16];
        idx2_next[o][j] = msb16(mp[o][16*j +: 16]);
      end
    end
  end

  // stage 3: shift each mantissa up to bit 52 and adjust its exponent
  always_comb begin
    logic [2:0][63:0] mp;
    logic [2:0][63:0] sh;
    logic [2:0][5:0]  pos;
    logic [2:0][5:0]  lz;
    mp[0] = {s2.ma, PAD_W'(0)};
    mp[1] = {s2.mb, PAD_W'(0)};
    mp[2] = {s2.side.mc, PAD_W'(0)};
    for (int o = 0; o < 3; o++) begin
      pos[o] = '0;
      for (int j = 0; j < 4; j++) begin
        if (nz2[o][j]) pos[o] = {2'(j), idx2[o][j]};
      end
      lz[o] = 6'd63 - pos[o];
      sh[o] = mp[o] << lz[o];
    end
    s3_next         = s2;
    s3_next.ma      = sh[0][63:PAD_W];
    s3_next.mb      = sh[1][63:PAD_W];
    s3_next.side.mc = sh[2][63:PAD_W];
    s3_next.ea      = s2.ea - exp_t'(lz[0]);
    s3_next.eb      = s2.eb - exp_t'(lz[1]);
    s3_next.side.ec = s2.side.ec - exp_t'(lz[2]);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= operand_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) begin
      s2   <= s1;
      nz2  <= nz2_next;
      idx2 <= idx2_next;
    end
    if (en3) s3 <= s3_next;
  end

  // finite nonzero operands leave normalized
  a_norm_msb: assert property (@(posedge clk) disable iff (rst)
    v3 && !s3.side.tag.special |-> s3.ma[MANT_W-1] && s3.mb[MANT_W-1])
    else $error("factor mantissa not normalized");

  a_norm_addend: assert property (@(posedge clk) disable iff (rst)
    v3 && !s3.side.tag.special && !s3.side.c_zero |-> s3.side.mc[MANT_W-1])
    else $error("addend mantissa not normalized");

endmodule

// ----- rtl/fmafp_mul.sv -----
// exact 53x53 mantissa product from four partial products (two stages)
module fmafp_mul import fmafp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  norm_valid,
  output logic  norm_ready,
  input  norm_t norm,
  output logic  prod_valid,
  input  logic  prod_ready,
  output prod_t prod
);

  localparam int LO_W = 32;
  localparam int HI_W = MANT_W - LO_W;

  logic v1, v2;
  logic en1, en2;
  side_t side1;
  exp_t  pe1;
  logic [2*LO_W-1:0]    p00;
  logic [MANT_W-1:0]    p01, p10;
  logic [2*HI_W-1:0]    p11;
  prod_t s2, s2_next;

  assign en2 = !v2 || prod_ready;
  assign en1 = !v1 || en2;
  assign norm_ready = en1;
  assign prod_valid = v2;
  assign prod       = s2;

  // stage 2: fold the partial products
  always_comb begin
    logic [MANT_W:0] mid;
    mid          = (MANT_W+1)'(p01) + (MANT_W+1)'(p10);
    s2_next.side = side1;
    s2_next.pe   = pe1;
    s2_next.p    = {p11, p00} + (PROD_W'(mid) << LO_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= norm_valid;
      if (en2) v2 <= v1;
    end
  end

  // stage 1: partial products, each at most 32x32
  always_ff @(posedge clk) begin
    if (en1) begin
      side1 <= norm.side;
      pe1   <= norm.ea + norm.eb;
      p00   <= (2*LO_W)'(norm.ma[LO_W-1:0]) * (2*LO_W)'(norm.mb[LO_W-1:0]);
      p01   <= MANT_W'(norm.ma[LO_W-1:0]) * MANT_W'(norm.mb[MANT_W-1:LO_W]);
      p10   <= MANT_W'(norm.ma[MANT_W-1:LO_W]) * MANT_W'(norm.mb[LO_W-1:0]);
      p11   <= (2*HI_W)'(norm.ma[MANT_W-1:LO_W]) * (2*HI_W)'(norm.mb[MANT_W-1:LO_W]);
    end
    if (en2) s2 <= s2_next;
  end

  // product of two normalized mantissas has its top one in the two highest bits
  a_prod_top: assert property (@(posedge clk) disable iff (rst)
    v2 && !s2.side.tag.special |-> s2.p[PROD_W-1] || s2.p[PROD_W-2])
    else $error("product lost its leading one");

endmodule

// ----- rtl/fmafp_add.sv -----
// addend alignment with sticky and the wide add or subtract (three stages)
module fmafp_add import fmafp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  prod_valid,
  output logic  prod_ready,
  input  prod_t prod,
  output logic  sum_valid,
  input  logic  sum_ready,
  output sum_t  sum
);

  typedef struct packed {
    tag_t              tag;
    logic [WIDE_W-1:0] big;
    logic [WIDE_W-1:0] lesser;
    logic [7:0]        d;
    logic              eff_sub;
    logic              rs;
    exp_t              e0;
  } align_t;

  logic v1, v2, v3;
  logic en1, en2, en3;
  align_t s1, s1_next, s2, s2_next;
  sum_t   s3, s3_next;

  assign en3 = !v3 || sum_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign prod_ready = en1;
  assign sum_valid  = v3;
  assign sum        = s3;

  // stage 1: put both leading ones at bit 125, order by magnitude
  always_comb begin
    logic [WIDE_W-1:0] p_w;
    logic [WIDE_W-1:0] z_w;
    exp_t              e_p;
    exp_t              e_c;
    exp_t              diff;
    logic              c_big;
    if (prod.p[PROD_W-1]) begin
      p_w = {2'b0, prod.p, 20'b0};
      e_p = prod.pe - exp_t'(20);
    end else begin
      p_w = {2'b0, prod.p[PROD_W-2:0], 21'b0};
      e_p = prod.pe - exp_t'(21);
    end
    z_w   = {2'b0, prod.side.mc, 73'b0};
    e_c   = prod.side.ec - exp_t'(73);
    c_big = !prod.side.c_zero &&
            ((e_c > e_p) || ((e_c == e_p) && (z_w > p_w)));
    diff  = c_big ? (e_c - e_p) : (e_p - e_c);
    s1_next.tag     = prod.side.tag;
    s1_next.eff_sub = prod.side.sp ^ prod.side.sc;
    if (prod.side.c_zero) begin
      s1_next.big    = p_w;
      s1_next.lesser = '0;
      s1_next.d      = '0;
      s1_next.rs     = prod.side.sp;
      s1_next.e0     = e_p;
    end else if (c_big) begin
      s1_next.big    = z_w;
      s1_next.lesser = p_w;
      s1_next.d      = (diff > exp_t'(255)) ? 8'hFF : diff[7:0];
      s1_next.rs     = prod.side.sc;
      s1_next.e0     = e_c;
    end else begin
      s1_next.big    = p_w;
      s1_next.lesser = z_w;
      s1_next.d      = (diff > exp_t'(255)) ? 8'hFF : diff[7:0];
      s1_next.rs     = prod.side.sp;
      s1_next.e0     = e_p;
    end
  end

  // stage 2: shift the lesser operand down, jam lost bits into bit 0
  always_comb begin
    logic              jam;
    jam     = |(s1.lesser & ~({WIDE_W{1'b1}} << s1.d));
    s2_next = s1;
    s2_next.lesser = (s1.lesser >> s1.d) | WIDE_W'(jam);
  end

  // stage 3: magnitude add or subtract
  always_comb begin
    s3_next.tag = s2.tag;
    s3_next.e0  = s2.e0;
    s3_next.rs  = s2.rs;
    s3_next.r   = s2.eff_sub ? (s2.big - s2.lesser) : (s2.big + s2.lesser);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= prod_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
  end

endmodule

// ----- rtl/fmafp_round.sv -----
// leading one search, rounding to nearest even and packing (four stages)
module fmafp_round import fmafp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    sum_valid,
  output logic    sum_ready,
  input  sum_t    sum,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int NCHUNK = WIDE_W / 16;
  localparam int Q_W    = MANT_W + 1;

  typedef struct packed {
    tag_t              tag;
    logic [WIDE_W-1:0] r;
    exp_t              sh;
    logic              ovf;
    logic              sub;
    logic              zero;
    logic [10:0]       exp_field;
    logic              rs;
  } rnd_t;

  typedef struct packed {
    tag_t        tag;
    logic [Q_W-1:0] q;
    logic        round_up;
    logic        ovf;
    logic        sub;
    logic        zero;
    logic [10:0] exp_field;
    logic        rs;
  } pack_t;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  sum_t s1;
  logic [NCHUNK-1:0]      nz1, nz1_next;
  logic [NCHUNK-1:0][3:0] idx1, idx1_next;
  rnd_t   s2, s2_next;
  pack_t  s3, s3_next;
  result_t s4, s4_next;
  mode_t   mode4;

  assign en4 = !v4 || result_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign sum_ready    = en1;
  assign result_valid = v4;
  assign result       = s4;

  // stage 1: per-chunk leading one
  always_comb begin
    for (int j = 0; j < NCHUNK; j++) begin
      nz1_next[j]  = |sum.r[16*j +: 16];
      idx1_next[j] = msb16(sum.r[16*j +: 16]);
    end
  end

  // stage 2: result exponent, range checks and rounding position
  always_comb begin
    logic [2:0] hi;
    logic [6:0] k;
    exp_t       eu;
    exp_t       tmp;
    logic       b32;
    hi = '0;
    for (int j = 0; j < NCHUNK; j++) begin
      if (nz1[j]) hi = 3'(j);
    end
    k   = {hi, idx1[hi]};
    eu  = s1.e0 + exp_t'(k);
    b32 = (s1.tag.mode == MODE_B32);
    s2_next.tag  = s1.tag;
    s2_next.r    = s1.r;
    s2_next.rs   = s1.rs;
    s2_next.zero = !(|nz1);
    s2_next.ovf  = eu >= (b32 ? EU_OVF32 : EU_OVF64);
    s2_next.sub  = eu < (b32 ? EMIN32 : EMIN64);
    s2_next.sh   = s2_next.sub ? ((b32 ? LSB_SUB32 : LSB_SUB64) - s1.e0)
                               : (exp_t'(k) - (b32 ? MB32 : MB64));
    tmp = eu + (b32 ? BIAS_M1_32 : BIAS_M1_64);
    s2_next.exp_field = tmp[10:0];
  end

  // stage 3: cut the sum at the rounding position, guard and sticky
  always_comb begin
    exp_t              neg;
    logic [7:0]        sh_c;
    logic [7:0]        sh_m1;
    logic [WIDE_W-1:0] shl;
    logic [WIDE_W-1:0] shr;
    logic [WIDE_W-1:0] hbits;
    logic              half;
    logic              rest;
    neg   = -s2.sh;
    sh_c  = (s2.sh > exp_t'(200)) ? 8'd200 : s2.sh[7:0];
    sh_m1 = sh_c - 8'd1;
    shl   = s2.r << neg[5:0];
    shr   = s2.r >> sh_c;
    hbits = s2.r >> sh_m1;
    half  = hbits[0];
    rest  = |(s2.r & ~({WIDE_W{1'b1}} << sh_m1));
    s3_next.tag       = s2.tag;
    s3_next.ovf       = s2.ovf;
    s3_next.sub       = s2.sub;
    s3_next.zero      = s2.zero;
    s3_next.exp_field = s2.exp_field;
    s3_next.rs        = s2.rs;
    if (s2.sh[EXP_W-1] || (s2.sh == '0)) begin
      s3_next.q        = shl[Q_W-1:0];
      s3_next.round_up = 1'b0;
    end else begin
      s3_next.q        = shr[Q_W-1:0];
      s3_next.round_up = half && (rest || shr[0]);
    end
  end

  // stage 4: increment, pack, saturate, and pick the special or zero result
  always_comb begin
    logic [Q_W-1:0] qr;
    logic [63:0]    b64;
    logic [63:0]    b32;
    logic [63:0]    bits;
    qr  = s3.q + Q_W'(s3.round_up);
    b64 = s3.sub ? {10'b0, qr} : ({1'b0, s3.exp_field, 52'b0} + {10'b0, qr});
    b32 = s3.sub ? {10'b0, qr} : ({33'b0, s3.exp_field[7:0], 23'b0} + {10'b0, qr});
    if (s3.tag.mode == MODE_B32) begin
      bits = (s3.ovf || (b32 >= INF32)) ? INF32 : b32;
      bits = bits | (s3.rs ? SIGN32 : 64'b0);
    end else begin
      bits = (s3.ovf || (b64 >= INF64)) ? INF64 : b64;
      bits = bits | (s3.rs ? SIGN64 : 64'b0);
    end
    if (s3.tag.special) begin
      s4_next.sum_bits     = s3.tag.spec_bits;
      s4_next.invalid_flag = s3.tag.spec_inv;
    end else if (s3.zero) begin
      s4_next.sum_bits     = '0;
      s4_next.invalid_flag = 1'b0;
    end else begin
      s4_next.sum_bits     = bits;
      s4_next.invalid_flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= sum_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1   <= sum;
      nz1  <= nz1_next;
      idx1 <= idx1_next;
    end
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
    if (en4) begin
      s4    <= s4_next;
      mode4 <= s3.tag.mode;
    end
  end

  // invalid only ever comes with the default quiet nan
  a_inv_dnan: assert property (@(posedge clk) disable iff (rst)
    v4 && s4.invalid_flag |-> (s4.sum_bits == QNAN64) || (s4.sum_bits == QNAN32))
    else $error("invalid raised without default nan");

  // single precision results keep the upper word clear
  a_b32_upper: assert property (@(posedge clk) disable iff (rst)
    v4 && (mode4 == MODE_B32) |-> s4.sum_bits[63:32] == '0)
    else $error("single precision result has upper bits set");

endmodule

// ----- rtl/fused_multiply_add_fp_unit.sv -----
// top level of the pipelined fused multiply-add unit
//
// Computes factor_a * factor_b + addend with one round to nearest, ties to
// even, in binary64 (mode 0) or binary32 in the low 32 bits (mode 1).
// Channels: operand beats in on operand_valid/operand_ready, result beats
// out on result_valid/result_ready, both plain valid/ready handshakes.
// An accepted operand beat reaches its result beat through
// 3 decode/normalize stages, 2 multiplier stages, 3 align/add stages and
// 4 normalize/round stages. Throughput is one beat per cycle while the
// receiver keeps result_ready high; the 53x53 product is built from four
// partial products of at most 32x32 bits in one stage and folded in the next.
// Each stage holds its own valid bit. When the receiver stalls, beats
// pile up into empty stages, so operands are still taken until the whole
// pipeline is full; nothing is dropped or repeated.
// A synchronous reset clears all valid bits; the payload registers are not reset.
module fused_multiply_add_fp_unit import fmafp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     operand_valid,
  output logic     operand_ready,
  input  operand_t operand,
  output logic     result_valid,
  input  logic     result_ready,
  output result_t  result
);

  logic  norm_valid, norm_ready;
  norm_t norm;
  logic  prod_valid, prod_ready;
  prod_t prod;
  logic  sum_valid, sum_ready;
  sum_t  sum;

  // decode and normalize
  fmafp_unpack u_unpack (
    .clk           (clk),
    .rst           (rst),
    .operand_valid (operand_valid),
    .operand_ready (operand_ready),
    .operand       (operand),
    .norm_valid    (norm_valid),
    .norm_ready    (norm_ready),
    .norm          (norm)
  );

  // mantissa product
  fmafp_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .norm_valid (norm_valid),
    .norm_ready (norm_ready),
    .norm       (norm),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  // alignment and add
  fmafp_add u_add (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum        (sum)
  );

  // rounding and packing
  fmafp_round u_round (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (sum_valid),
    .sum_ready    (sum_ready),
    .sum          (sum),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- verif/fused_multiply_add_fp_unit_tb.sv -----
// testbench for the pipelined fused multiply-add unit with a bit-exact predictor
module fused_multiply_add_fp_unit_tb import fmafp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 12;
  localparam int CYCLE_LIMIT = 400000;

  // predicted sum and flag of one operand beat
  typedef struct {
    logic [63:0] sum_bits;
    logic        invalid_flag;
  } fma_expect_t;

  // exact product plus addend, one rounding, per the selected format
  function automatic fma_expect_t predict_fma(input operand_t op);
    fma_expect_t      res;
    int               mb;
    int               eb;
    int               bias;
    int               emax;
    logic [63:0]      mask;
    logic [63:0]      fm;
    logic [63:0]      qbit;
    logic [63:0]      sbit;
    logic [63:0]      infb;
    logic [63:0]      a;
    logic [63:0]      b;
    logic [63:0]      c;
    logic [63:0]      fa;
    logic [63:0]      fb;
    logic [63:0]      fc;
    int               xa;
    int               xb;
    int               xc;
    logic             sa;
    logic             sb;
    logic             sc;
    logic             sp;
    logic             rs;
    logic             s_big;
    logic             s_small;
    logic             na;
    logic             nb;
    logic             nc;
    logic             ia;
    logic             ib;
    logic             ic;
    logic             za;
    logic             zb;
    logic             zc;
    logic [127:0]     p;
    logic [127:0]     z;
    logic [127:0]     big;
    logic [127:0]     sml;
    logic [127:0]     r;
    logic [127:0]     lowmask;
    logic [63:0]      ma;
    logic [63:0]      mbv;
    logic [63:0]      mc;
    logic [63:0]      q;
    logic [63:0]      bits;
    int               kp;
    int               kc;
    int               k;
    int               e_big;
    int               e_small;
    int               e0;
    int               eu;
    int               emin;
    int               lsbe;
    int               sh;
    int               d;
    int               t;
    logic             jam;
    logic             half;
    logic             rest;
    if (op.mode == MODE_B32) begin
      mb = 23;
      eb = 8;
      mask = 64'hFFFF_FFFF;
    end else begin
      mb = 52;
      eb = 11;
      mask = '1;
    end
    emax = (1 << eb) - 1;
    bias = (1 << (eb - 1)) - 1;
    fm = (64'd1 << mb) - 1;
    qbit = 64'd1 << (mb - 1);
    sbit = 64'd1 << (mb + eb);
    infb = 64'(emax) << mb;
    res.invalid_flag = 1'b0;
    a = op.factor_a & mask;
    b = op.factor_b & mask;
    c = op.addend & mask;
    xa = int'((a >> mb) & 64'(emax));
    xb = int'((b >> mb) & 64'(emax));
    xc = int'((c >> mb) & 64'(emax));
    fa = a & fm;
    fb = b & fm;
    fc = c & fm;
    sa = a[mb + eb];
    sb = b[mb + eb];
    sc = c[mb + eb];
    na = xa == emax && fa != 0;
    ia = xa == emax && fa == 0;
    za = xa == 0 && fa == 0;
    nb = xb == emax && fb != 0;
    ib = xb == emax && fb == 0;
    zb = xb == 0 && fb == 0;
    nc = xc == emax && fc != 0;
    ic = xc == emax && fc == 0;
    zc = xc == 0 && fc == 0;
    sp = sa ^ sb;
    // special operands first
    if (na) begin
      res.sum_bits = a | qbit;
      return res;
    end
    if (nb) begin
      res.sum_bits = b | qbit;
      return res;
    end
    if ((za && ib) || (zb && ia)) begin
      res.invalid_flag = 1'b1;
      res.sum_bits = infb | qbit;
      return res;
    end
    if (ia || ib) begin
      if (nc) res.sum_bits = c | qbit;
      else if (ic && sc != sp) begin
        res.invalid_flag = 1'b1;
        res.sum_bits = infb | qbit;
      end else res.sum_bits = (sp ? sbit : 64'd0) | infb;
      return res;
    end
    if (nc) begin
      res.sum_bits = c | qbit;
      return res;
    end
    if (ic) begin
      res.sum_bits = c;
      return res;
    end
    if (za || zb) begin
      if (zc) res.sum_bits = (sp && sc) ? sbit : 64'd0;
      else res.sum_bits = c;
      return res;
    end
    // exact product, normalized so its msb sits at bit 125
    ma = fa | (xa != 0 ? (64'd1 << mb) : 64'd0);
    mbv = fb | (xb != 0 ? (64'd1 << mb) : 64'd0);
    p = 128'(ma) * 128'(mbv);
    kp = 0;
    for (int i = 0; i < 128; i++) if (p[i]) kp = i;
    p = p << (125 - kp);
    e_big = ((xa != 0 ? xa : 1) - bias - mb) + ((xb != 0 ? xb : 1) - bias - mb) - (125 - kp);
    if (zc) begin
      r = p;
      e0 = e_big;
      rs = sp;
    end else begin
      mc = fc | (xc != 0 ? (64'd1 << mb) : 64'd0);
      z = 128'(mc);
      kc = 0;
      for (int i = 0; i < 128; i++) if (z[i]) kc = i;
      z = z << (125 - kc);
      e_small = ((xc != 0 ? xc : 1) - bias - mb) - (125 - kc);
      if (e_big >= e_small) begin
        big = p;
        s_big = sp;
        sml = z;
        s_small = sc;
      end else begin
        t = e_big;
        e_big = e_small;
        e_small = t;
        big = z;
        s_big = sc;
        sml = p;
        s_small = sp;
      end
      // align the smaller term with a sticky bit
      d = e_big - e_small;
      if (d >= 128) begin
        jam = sml != 0;
        sml = '0;
      end else begin
        lowmask = (128'd1 << d) - 1;
        jam = (sml & lowmask) != 0;
        sml = sml >> d;
      end
      if (jam) sml[0] = 1'b1;
      e0 = e_big;
      if (s_big == s_small) begin
        r = big + sml;
        rs = s_big;
      end else if (big < sml) begin
        r = sml - big;
        rs = s_small;
      end else begin
        r = big - sml;
        rs = s_big;
      end
      if (r == 0) begin
        res.sum_bits = '0;
        return res;
      end
    end
    // round once to nearest even
    k = 0;
    for (int i = 0; i < 128; i++) if (r[i]) k = i;
    eu = e0 + k;
    emin = 1 - bias;
    if (eu + bias >= emax) begin
      res.sum_bits = (rs ? sbit : 64'd0) | infb;
      return res;
    end
    lsbe = ((eu < emin) ? emin : eu) - mb;
    sh = lsbe - e0;
    if (sh <= 0) q = 64'(r << (-sh));
    else begin
      half = (sh <= 128) ? r[sh - 1] : 1'b0;
      lowmask = (128'd1 << (sh - 1)) - 1;
      rest = (r & lowmask) != 0;
      q = 64'(r >> sh);
      if (half && (rest || q[0])) q = q + 1;
    end
    if (eu < emin) bits = q;
    else bits = (64'(eu + bias - 1) << mb) + q;
    if (bits >= infb) bits = infb;
    res.sum_bits = (rs ? sbit : 64'd0) | bits;
    return res;
  endfunction

  // in-order store of predicted results
  class fma_scoreboard;
    fma_expect_t pending[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function void note_operand(operand_t op);
      pending.push_back(predict_fma(op));
    endfunction

    function void check_result(result_t got);
      fma_expect_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result sum_bits=%h invalid_flag=%b", $realtime,
                 got.sum_bits, got.invalid_flag);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.sum_bits !== want.sum_bits) begin
        $display("%0t: sum_bits mismatch expected %h actual %h", $realtime,
                 want.sum_bits, got.sum_bits);
        errors++;
      end
      if (got.invalid_flag !== want.invalid_flag) begin
        $display("%0t: invalid_flag mismatch expected %b actual %b", $realtime,
                 want.invalid_flag, got.invalid_flag);
        errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     operand_valid;
  logic     operand_ready;
  operand_t operand;
  logic     result_valid;
  logic     result_ready;
  result_t  result;

  fma_scoreboard sb;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            cycles;

  fused_multiply_add_fp_unit u_top (
    .clk(clk),
    .rst(rst),
    .operand_valid(operand_valid),
    .operand_ready(operand_ready),
    .operand(operand),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side: random stall and check on each accepted beat
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
    if (rst) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // random bits of one format with a class bias
  function automatic logic [63:0] rand_float(input mode_t m);
    logic [63:0] v;
    int          sel;
    v = {$urandom, $urandom};
    sel = $urandom_range(9);
    if (m == MODE_B32) begin
      case (sel)
        0: v[30:23] = '0;
        1: v[30:23] = '1;
        2: v[30:0] = '0;
        3: v[30:23] = 8'd127 + 8'($urandom_range(6)) - 8'd3;
        default: ;
      endcase
    end else begin
      case (sel)
        0: v[62:52] = '0;
        1: v[62:52] = '1;
        2: v[62:0] = '0;
        3: v[62:52] = 11'd1023 + 11'($urandom_range(6)) - 11'd3;
        default: ;
      endcase
    end
    return v;
  endfunction

  // one operand beat, with optional idle cycles before it
  task automatic send_operand(input operand_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      operand_valid <= 1'b0;
      @(posedge clk);
    end
    operand_valid <= 1'b1;
    operand <= op;
    do @(posedge clk); while (!operand_ready);
    sb.note_operand(op);
  endtask

  task automatic send_case(input mode_t m, input logic [63:0] a, input logic [63:0] b,
                           input logic [63:0] c);
    operand_t op;
    op.mode = m;
    op.factor_a = a;
    op.factor_b = b;
    op.addend = c;
    send_operand(op);
  endtask

  // a random beat that often cancels or sits near the addend
  task automatic send_random();
    operand_t op;
    op.mode = mode_t'($urandom_range(1));
    op.factor_a = rand_float(op.mode);
    op.factor_b = rand_float(op.mode);
    op.addend = rand_float(op.mode);
    if ($urandom_range(7) == 0) begin
      // addend minus a times one, exact cancellation or near it
      op.factor_b = (op.mode == MODE_B32) ? {$urandom, 32'h3F80_0000} : 64'h3FF0_0000_0000_0000;
      op.addend = op.factor_a ^ ((op.mode == MODE_B32) ? SIGN32 : SIGN64);
      if ($urandom_range(1)) op.addend[0] = ~op.addend[0];
    end
    send_operand(op);
  endtask

  task automatic drain();
    operand_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    operand_valid = 1'b0;
    operand = '0;
    send_idle_pct = 17;
    recv_idle_pct = 57;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: specials, overflow, subnormals and cancellation of both formats
    send_case(MODE_B64, INF64, 64'd0, 64'h3FF0_0000_0000_0000);
    send_case(MODE_B64, 64'd0, INF64 | SIGN64, QNAN64);
    send_case(MODE_B64, 64'h7FF0_0000_0000_0001, 64'h7FF4_0000_0000_0000, 64'd0);
    send_case(MODE_B64, 64'h4000_0000_0000_0000, 64'h7FF0_0000_0000_0005, 64'd0);
    send_case(MODE_B64, INF64, 64'h4000_0000_0000_0000, INF64 | SIGN64);
    send_case(MODE_B64, INF64, 64'h4000_0000_0000_0000, INF64);
    send_case(MODE_B64, INF64, 64'h4000_0000_0000_0000, 64'h7FF0_0000_0000_0009);
    send_case(MODE_B64, 64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, 64'hFFF1_0000_0000_0000);
    send_case(MODE_B64, 64'h4000_0000_0000_0000, 64'h4000_0000_0000_0000, INF64 | SIGN64);
    send_case(MODE_B64, SIGN64, 64'h4000_0000_0000_0000, SIGN64);
    send_case(MODE_B64, SIGN64, 64'h4000_0000_0000_0000, 64'd0);
    send_case(MODE_B64, 64'd0, 64'd5, 64'h8000_0000_0000_0003);
    send_case(MODE_B64, 64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000);
    send_case(MODE_B64, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'd0);
    send_case(MODE_B64, 64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000, 64'd0);
    send_case(MODE_B64, 64'h000F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001, 64'h8000_0000_0000_0001);
    send_case(MODE_B64, '1, '1, '1);
    send_case(MODE_B32, 64'hFFFF_FFFF_7F80_0000, 64'h1234_5678_0000_0000, 64'd0);
    send_case(MODE_B32, 64'hFFFF_FFFF_7F80_0001, 64'd0, 64'd0);
    send_case(MODE_B32, 64'h7F80_0000, 64'h4000_0000, 64'hFF80_0000);
    send_case(MODE_B32, 64'h7F7F_FFFF, 64'h7F7F_FFFF, 64'hFF7F_FFFF);
    send_case(MODE_B32, 64'h0000_0001, 64'h3F00_0000, 64'h8000_0000);
    send_case(MODE_B32, 64'h3F80_0001, 64'h3F80_0001, 64'hBF80_0002);
    send_case(MODE_B32, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h8000_0000);
    drain();

    // random phases with different idle mixes
    for (int i = 0; i < 320; i++) send_random();
    drain();
    send_idle_pct = 57;
    recv_idle_pct = 17;
    for (int i = 0; i < 320; i++) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 310; i++) send_random();
    drain();

    repeat (LATENCY + 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
